/* design/hps_pkg.sv */
// ----------------------------------------------------------------------------
// hps_pkg
// shared types and constants for the heater profile sequencer
// ----------------------------------------------------------------------------
package hps_pkg;

  localparam int TEMP_WIDTH = 16;
  localparam int DUR_WIDTH  = 32;
  localparam int TOL_WIDTH  = 12;
  localparam int QUO_WIDTH  = 16;

  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_RAMP  = 2'd1;
  localparam logic [1:0] MODE_HOLD  = 2'd2;
  localparam logic [1:0] MODE_TIMER = 2'd3;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;

  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_RSTART   = 3'd1;
  localparam logic [2:0] REG_REND     = 3'd2;
  localparam logic [2:0] REG_SETPOINT = 3'd3;
  localparam logic [2:0] REG_DURATION = 3'd4;
  localparam logic [2:0] REG_TOL      = 3'd5;
  localparam logic [2:0] REG_TUS      = 3'd6;
  localparam logic [2:0] REG_HYST     = 3'd7;

  typedef struct packed {
    logic [1:0]                   profile_mode;
    logic signed [TEMP_WIDTH-1:0] ramp_start_temp;
    logic signed [TEMP_WIDTH-1:0] ramp_end_temp;
    logic signed [TEMP_WIDTH-1:0] setpoint_temp;
    logic [DUR_WIDTH-1:0]         profile_duration_ms;
    logic [TOL_WIDTH-1:0]         band_tolerance;
    logic                         timer_uses_setpoint;
    logic [TOL_WIDTH-1:0]         restart_margin;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic [DUR_WIDTH-1:0] rem_init;
    logic [QUO_WIDTH-1:0] num_lo;
    logic [DUR_WIDTH-1:0] den;
  } div_req_t;

endpackage

/* design/heater_profile_sequencer_core.sv */
// ----------------------------------------------------------------------------
// heater_profile_sequencer_core
// heater profile sequencer: off, ramp, hold and timer modes
// ----------------------------------------------------------------------------
// sequence: accept, multiply, then one shared divider run twice (ramp
// fraction, then progress) at one quotient bit per cycle, then result valid
// input not ready while an item is at work
// reset: synchronous active high, mode off, elapsed zero, registers to defaults
// ----------------------------------------------------------------------------
module heater_profile_sequencer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  // action[1:0], current_temp[17:2], heater_fault[18], heater_running[19],
  // ms_passed[35:20]
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // cmd_start[0], cmd_stop[1], set_target[2], clear_target[3], target_temp[19:4],
  // target_tolerance[31:20], completed[32], faulted[33], mode_now[35:34],
  // done_flag[36], progress[53:37], remaining_ms[85:54]
  output logic [87:0] m_tdata
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL  = 7'b0000010,
    ST_DRGO = 7'b0000100,
    ST_DR   = 7'b0001000,
    ST_DPGO = 7'b0010000,
    ST_DP   = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_t;

  localparam int TW = hps_pkg::TEMP_WIDTH;

  hps_pkg::cfg_t     cfg;
  hps_pkg::div_req_t dreq;
  logic [15:0]       quo;
  logic              div_done;

  state_t            state;
  logic [1:0]        mode;
  logic [31:0]       elapsed;
  logic              c_start, c_stop, c_set, c_clear, c_done, c_fault, use_ramp;
  logic signed [TW-1:0] cmd_t;
  logic [47:0]       prod;
  logic [15:0]       mag;

  logic [1:0]        act;
  logic signed [TW-1:0] cur;
  logic              fault, running;
  logic [15:0]       ms;
  logic              acc;

  assign act     = s_tdata[1:0];
  assign cur     = s_tdata[17:2];
  assign fault   = s_tdata[18];
  assign running = s_tdata[19];
  assign ms      = s_tdata[35:20];
  assign s_tready = (state == ST_IDLE);
  assign acc      = s_tvalid && s_tready;

  hps_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  hps_divider u_div (.clk(clk), .rst(rst), .req(dreq), .quo(quo), .done(div_done));

  // ramp geometry
  logic signed [TW:0] diff;
  logic [TW-1:0]      amag;
  logic               up;
  logic [31:0]        dur;
  logic               e_ge;
  assign dur  = cfg.profile_duration_ms;
  assign diff = {cfg.ramp_end_temp[TW-1], cfg.ramp_end_temp}
              - {cfg.ramp_start_temp[TW-1], cfg.ramp_start_temp};
  assign up   = !diff[TW];
  assign amag = up ? diff[TW-1:0] : TW'(-diff);

  // step decision
  logic [1:0]  mode_n;
  logic [31:0] el_n;
  logic        s_n, p_n, set_n, clr_n, dn_n, f_n, ur_n, off_n;
  logic signed [TW-1:0] cmdt_n;
  logic [32:0] sum;
  logic signed [TW+1:0] thr;
  logic        el_ge;

  assign sum   = {1'b0, elapsed} + {17'd0, ms};
  assign thr   = {{2{cfg.setpoint_temp[TW-1]}}, cfg.setpoint_temp}
               - {{(TW-10){1'b0}}, cfg.restart_margin};

  always_comb begin
    mode_n = mode; el_n = elapsed;
    s_n = 1'b0; p_n = 1'b0; set_n = 1'b0; clr_n = 1'b0; dn_n = 1'b0; f_n = 1'b0;
    ur_n = 1'b0; off_n = 1'b0; cmdt_n = '0; el_ge = 1'b0;
    case (act)
      hps_pkg::ACT_START: begin
        el_n = '0;
        case (cfg.profile_mode)
          hps_pkg::MODE_RAMP: begin
            mode_n = hps_pkg::MODE_RAMP; set_n = 1'b1; s_n = 1'b1;
            cmdt_n = cfg.ramp_start_temp;
          end
          hps_pkg::MODE_HOLD: begin
            mode_n = hps_pkg::MODE_HOLD; set_n = 1'b1; s_n = 1'b1;
            cmdt_n = cfg.setpoint_temp;
          end
          hps_pkg::MODE_TIMER: begin
            mode_n = hps_pkg::MODE_TIMER; s_n = 1'b1;
            set_n = cfg.timer_uses_setpoint; cmdt_n = cfg.setpoint_temp;
          end
          default: off_n = 1'b1;
        endcase
      end
      hps_pkg::ACT_STOP: off_n = 1'b1;
      hps_pkg::ACT_TICK: begin
        el_n  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        el_ge = el_n >= dur;
        if (fault) begin
          f_n = 1'b1; off_n = 1'b1;
        end else begin
          case (mode)
            hps_pkg::MODE_OFF: p_n = running;
            hps_pkg::MODE_RAMP: begin
              set_n = 1'b1;
              if (el_ge) begin
                cmdt_n = cfg.ramp_end_temp; dn_n = 1'b1; off_n = 1'b1;
              end else begin
                ur_n = 1'b1; s_n = !running;
              end
            end
            hps_pkg::MODE_HOLD: s_n = !running && ($signed({{2{cur[TW-1]}}, cur}) < thr);
            default: begin
              if (el_ge) begin
                dn_n = 1'b1; off_n = 1'b1;
              end else begin
                s_n = !running;
              end
            end
          endcase
        end
      end
      default: ;
    endcase
    if (off_n) begin
      mode_n = hps_pkg::MODE_OFF; p_n = 1'b1; clr_n = 1'b1;
    end
  end

  assign e_ge = elapsed >= dur;

  always_comb begin
    dreq.start    = (state == ST_DRGO) || (state == ST_DPGO);
    dreq.den      = dur;
    dreq.rem_init = (state == ST_DRGO) ? prod[47:16] : elapsed;
    dreq.num_lo   = (state == ST_DRGO) ? prod[15:0] : 16'd0;
  end

  // result assembly
  logic signed [TW:0]   rsum;
  logic signed [TW-1:0] ramp_val, tgt;
  logic                 done_f;
  logic [16:0]          prog;
  logic [31:0]          remv;
  logic                 out_free;

  assign rsum     = up ? {cfg.ramp_start_temp[TW-1], cfg.ramp_start_temp} + {1'b0, mag}
                       : {cfg.ramp_start_temp[TW-1], cfg.ramp_start_temp} - {1'b0, mag};
  assign ramp_val = e_ge ? cfg.ramp_end_temp : rsum[TW-1:0];
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    case (mode)
      hps_pkg::MODE_RAMP, hps_pkg::MODE_TIMER: begin
        done_f = e_ge;
        prog   = e_ge ? 17'h10000 : {1'b0, quo};
        remv   = e_ge ? 32'd0 : dur - elapsed;
        tgt    = (mode == hps_pkg::MODE_RAMP) ? ramp_val :
                 (cfg.timer_uses_setpoint ? cfg.setpoint_temp : '0);
      end
      hps_pkg::MODE_HOLD: begin
        done_f = 1'b0; prog = '0; remv = '0; tgt = cfg.setpoint_temp;
      end
      default: begin
        done_f = 1'b1; prog = 17'h10000; remv = '0; tgt = '0;
      end
    endcase
    if (c_set) tgt = use_ramp ? ramp_val : cmd_t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      mode     <= hps_pkg::MODE_OFF;
      elapsed  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == ST_FIN && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: if (acc) begin
          state <= ST_MUL; mode <= mode_n; elapsed <= el_n;
        end
        ST_MUL:  state <= ST_DRGO;
        ST_DRGO: state <= ST_DR;
        ST_DR:   if (div_done) state <= ST_DPGO;
        ST_DPGO: state <= ST_DP;
        ST_DP:   if (div_done) state <= ST_FIN;
        ST_FIN:  if (out_free) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      c_start <= s_n; c_stop <= p_n; c_set <= set_n; c_clear <= clr_n;
      c_done <= dn_n; c_fault <= f_n; use_ramp <= ur_n; cmd_t <= cmdt_n;
    end
    if (state == ST_MUL) prod <= {16'd0, amag} * {16'd0, elapsed};
    if (state == ST_DR && div_done) mag <= quo;
    if (state == ST_FIN && out_free)
      m_tdata <= {2'b00, remv, prog, done_f, mode, c_fault, c_done,
                  cfg.band_tolerance, tgt, c_clear, c_set, c_stop, c_start};
  end

  a_div_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DR || state == ST_DP))
    else $error("divider finished outside a wait state");

  a_acc_to_mul: assert property (@(posedge clk) disable iff (rst)
    acc |=> state == ST_MUL)
    else $error("accepted item did not start the sequence");

  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && m_tvalid && !m_tready) |=> state == ST_FIN)
    else $error("result overwrote a pending output item");

  a_no_ready_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN) |-> !s_tready)
    else $error("input ready while an item is at work");

endmodule

/* design/hps_cfg.sv */
// ----------------------------------------------------------------------------
// hps_cfg
// apb register file holding the profile configuration
// ----------------------------------------------------------------------------
module hps_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output hps_pkg::cfg_t     cfg
);

  logic [2:0] idx;
  logic       wr;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.profile_mode        <= '0;
      cfg.ramp_start_temp     <= '0;
      cfg.ramp_end_temp       <= '0;
      cfg.setpoint_temp       <= '0;
      cfg.profile_duration_ms <= '0;
      cfg.band_tolerance      <= 12'd16;
      cfg.timer_uses_setpoint <= 1'b0;
      cfg.restart_margin      <= 12'd16;
    end else if (wr) begin
      case (idx)
        hps_pkg::REG_MODE:     cfg.profile_mode        <= pwdata[1:0];
        hps_pkg::REG_RSTART:   cfg.ramp_start_temp     <= pwdata[15:0];
        hps_pkg::REG_REND:     cfg.ramp_end_temp       <= pwdata[15:0];
        hps_pkg::REG_SETPOINT: cfg.setpoint_temp       <= pwdata[15:0];
        hps_pkg::REG_DURATION: cfg.profile_duration_ms <= pwdata;
        hps_pkg::REG_TOL:      cfg.band_tolerance      <= pwdata[11:0];
        hps_pkg::REG_TUS:      cfg.timer_uses_setpoint <= pwdata[0];
        hps_pkg::REG_HYST:     cfg.restart_margin      <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      hps_pkg::REG_MODE:     prdata = {30'd0, cfg.profile_mode};
      hps_pkg::REG_RSTART:   prdata = {16'd0, cfg.ramp_start_temp};
      hps_pkg::REG_REND:     prdata = {16'd0, cfg.ramp_end_temp};
      hps_pkg::REG_SETPOINT: prdata = {16'd0, cfg.setpoint_temp};
      hps_pkg::REG_DURATION: prdata = cfg.profile_duration_ms;
      hps_pkg::REG_TOL:      prdata = {20'd0, cfg.band_tolerance};
      hps_pkg::REG_TUS:      prdata = {31'd0, cfg.timer_uses_setpoint};
      hps_pkg::REG_HYST:     prdata = {20'd0, cfg.restart_margin};
      default:               prdata = '0;
    endcase
  end

endmodule

/* design/hps_divider.sv */
// ----------------------------------------------------------------------------
// hps_divider
// restoring divider, one quotient bit per cycle; the remainder must start below den, which the divider does not check
// ----------------------------------------------------------------------------
module hps_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  hps_pkg::div_req_t             req,
  output logic [hps_pkg::QUO_WIDTH-1:0] quo,
  output logic                          done
);

  logic [hps_pkg::DUR_WIDTH-1:0] rem;
  logic [hps_pkg::QUO_WIDTH-1:0] lo;
  logic [hps_pkg::DUR_WIDTH-1:0] den;
  logic [4:0]                    cnt;
  logic [hps_pkg::DUR_WIDTH:0]   trial;
  logic                          ge;

  assign trial = {rem, lo[hps_pkg::QUO_WIDTH-1]};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (req.start) begin
      cnt  <= 5'(hps_pkg::QUO_WIDTH);
      done <= 1'b0;
    end else begin
      done <= (cnt == 5'd1);
      if (cnt != 5'd0) cnt <= cnt - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.rem_init;
      lo  <= req.num_lo;
      den <= req.den;
    end else if (cnt != 5'd0) begin
      rem <= ge ? 32'(trial - {1'b0, den}) : trial[hps_pkg::DUR_WIDTH-1:0];
      lo  <= {lo[hps_pkg::QUO_WIDTH-2:0], 1'b0};
      quo <= {quo[hps_pkg::QUO_WIDTH-2:0], ge};
    end
  end

endmodule
